FILE: src/prq_pkg.sv
`default_nettype none

package prq_pkg;

	localparam int ID_W = 5;
	localparam int PRIO_IN_W = 8;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_SET_READY = 2'd1,
		OP_PICK = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: src/prq_ram.sv
`default_nettype none

module prq_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/priority_ready_queue_unit.sv
// A word with a walk (enqueue, set-ready, pick) walks the slot store from slot zero up to
// the last slot and then shows its result word; a walk ends early at the first empty slot.
// The slot store is visited one slot per cycle through a single RAM read port and a single
// write port. A new word is accepted only in the idle state, once the last result is loaded.
// No-op, and enqueue or set-ready with task id zero, skip the walk and go straight to the
// result word. Reset: per-slot valid bits clear at once.
`default_nettype none

module priority_ready_queue_unit #(
	parameter int SLOTS = 16,
	parameter int PRIORITY_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] operation,
	input wire logic [prq_pkg::ID_W-1:0] task_id,
	input wire logic [prq_pkg::PRIO_IN_W-1:0] task_priority,
	input wire logic ready_flag,
	output logic out_valid,
	input wire logic out_ready,
	output logic picked_valid,
	output logic [prq_pkg::ID_W-1:0] picked_id,
	output logic overflow
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int EW = prq_pkg::ID_W + PRIORITY_BITS + 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

	prq_pkg::state_t state_q, state_d;
	prq_pkg::op_t op_q;

	logic [prq_pkg::ID_W-1:0] item_id_q;
	logic [PRIORITY_BITS-1:0] item_prio_q;
	logic item_rdy_q;
	logic [PRIORITY_BITS-1:0] in_prio;

	logic [IDX_W-1:0] rd_idx_q;
	logic issue_q;
	logic proc_s1;
	logic [IDX_W-1:0] idx_s1;
	logic moving_q;
	logic found_q;
	logic res_valid_q;
	logic [prq_pkg::ID_W-1:0] res_id_q;
	logic res_ovf_q;
	logic [SLOTS-1:0] valid_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic ram_re;
	logic [EW-1:0] ram_rdata;

	logic [prq_pkg::ID_W-1:0] rd_id;
	logic [PRIORITY_BITS-1:0] rd_prio;
	logic rd_rdy;
	logic occ;
	logic last;

	logic accept;
	logic start_walk;
	logic finish;
	logic v_we;
	logic [IDX_W-1:0] v_idx;
	logic v_val;
	logic clr_last;
	logic item_load;
	logic moving_d;
	logic found_set;
	logic ovf_set;
	logic load_out;

	generate
		if (PRIORITY_BITS <= prq_pkg::PRIO_IN_W) begin : g_prio_trunc
			assign in_prio = task_priority[PRIORITY_BITS-1:0];
		end else begin : g_prio_ext
			assign in_prio = {{(PRIORITY_BITS - prq_pkg::PRIO_IN_W){1'b0}}, task_priority};
		end
	endgenerate

	assign rd_id = ram_rdata[EW-1 -: prq_pkg::ID_W];
	assign rd_prio = ram_rdata[PRIORITY_BITS:1];
	assign rd_rdy = ram_rdata[0];
	assign occ = valid_q[idx_s1] && (rd_id != '0);
	assign last = (idx_s1 == LAST);

	assign accept = in_valid && in_ready;
	assign ram_re = (state_q == prq_pkg::ST_WALK) && issue_q;

	prq_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		start_walk = 1'b0;
		finish = 1'b0;
		ram_we = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = {item_id_q, item_prio_q, item_rdy_q};
		v_we = 1'b0;
		v_idx = idx_s1;
		v_val = 1'b0;
		clr_last = 1'b0;
		item_load = 1'b0;
		moving_d = moving_q;
		found_set = 1'b0;
		ovf_set = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			prq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (prq_pkg::op_t'(operation) == prq_pkg::OP_PICK ||
						((prq_pkg::op_t'(operation) == prq_pkg::OP_ENQUEUE ||
						prq_pkg::op_t'(operation) == prq_pkg::OP_SET_READY) &&
						task_id != '0)) begin
						start_walk = 1'b1;
						state_d = prq_pkg::ST_WALK;
					end else begin
						state_d = prq_pkg::ST_DONE;
					end
				end
			end
			prq_pkg::ST_WALK: begin
				if (proc_s1) begin
					case (op_q)
						prq_pkg::OP_ENQUEUE: begin
							if (!occ) begin
								ram_we = 1'b1;
								v_we = 1'b1;
								v_val = 1'b1;
								finish = 1'b1;
							end else begin
								moving_d = moving_q || (rd_prio < item_prio_q);
								if (moving_d) begin
									ram_we = 1'b1;
									item_load = 1'b1;
								end
								if (last) begin
									ovf_set = 1'b1;
									finish = 1'b1;
								end
							end
						end
						prq_pkg::OP_SET_READY: begin
							if (!occ) begin
								finish = 1'b1;
							end else begin
								if (rd_id == item_id_q && rd_prio == item_prio_q) begin
									ram_we = 1'b1;
									ram_wdata = {rd_id, rd_prio, item_rdy_q};
								end
								if (last) begin
									finish = 1'b1;
								end
							end
						end
						prq_pkg::OP_PICK: begin
							if (!found_q) begin
								if (!occ) begin
									finish = 1'b1;
								end else if (rd_rdy) begin
									found_set = 1'b1;
									if (last) begin
										clr_last = 1'b1;
										finish = 1'b1;
									end
								end else if (last) begin
									finish = 1'b1;
								end
							end else begin
								ram_we = occ;
								ram_waddr = idx_s1 - IDX_W'(1);
								ram_wdata = ram_rdata;
								v_we = 1'b1;
								v_idx = idx_s1 - IDX_W'(1);
								v_val = occ;
								if (!occ) begin
									finish = 1'b1;
								end else if (last) begin
									clr_last = 1'b1;
									finish = 1'b1;
								end
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
				if (finish) begin
					state_d = prq_pkg::ST_DONE;
				end
			end
			prq_pkg::ST_DONE: begin
				if (!out_valid || out_ready) begin
					load_out = 1'b1;
					state_d = prq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = prq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			proc_s1 <= 1'b0;
			rd_idx_q <= '0;
			idx_s1 <= '0;
			moving_q <= 1'b0;
			found_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_id_q <= '0;
			res_ovf_q <= 1'b0;
			valid_q <= '0;
			out_valid <= 1'b0;
			picked_valid <= 1'b0;
			picked_id <= '0;
			overflow <= 1'b0;
		end else begin
			if (accept) begin
				issue_q <= start_walk;
				proc_s1 <= 1'b0;
				rd_idx_q <= '0;
				moving_q <= 1'b0;
				found_q <= 1'b0;
				res_valid_q <= 1'b0;
				res_id_q <= '0;
				res_ovf_q <= 1'b0;
			end else if (state_q == prq_pkg::ST_WALK) begin
				proc_s1 <= issue_q && !finish;
				idx_s1 <= rd_idx_q;
				moving_q <= moving_d;
				if (issue_q) begin
					if (rd_idx_q == LAST || finish) begin
						issue_q <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				if (finish) begin
					issue_q <= 1'b0;
				end
				if (found_set) begin
					found_q <= 1'b1;
					res_valid_q <= 1'b1;
					res_id_q <= rd_id;
				end
				if (ovf_set) begin
					res_ovf_q <= 1'b1;
				end
			end
			if (v_we) begin
				valid_q[v_idx] <= v_val;
			end
			if (clr_last) begin
				valid_q[SLOTS-1] <= 1'b0;
			end
			if (load_out) begin
				out_valid <= 1'b1;
				picked_valid <= res_valid_q;
				picked_id <= res_id_q;
				overflow <= res_ovf_q;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_load) begin
			item_id_q <= rd_id;
			item_prio_q <= rd_prio;
			item_rdy_q <= rd_rdy;
		end else if (accept) begin
			op_q <= prq_pkg::op_t'(operation);
			item_id_q <= task_id;
			item_prio_q <= in_prio;
			item_rdy_q <= ready_flag;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (picked_valid == (picked_id != '0)))
		else $error("picked_valid disagrees with picked_id");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !picked_valid)
		else $error("overflow and pick result in one word");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == prq_pkg::ST_WALK) && proc_s1)
		else $error("store written outside a walk");

	assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (state_q == prq_pkg::ST_DONE) && !proc_s1)
		else $error("walk did not end after finish");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == prq_pkg::ST_WALK) && ram_we && (op_q == prq_pkg::OP_PICK) |->
		found_q && (idx_s1 != '0))
		else $error("pick shift without a found entry");

endmodule

`default_nettype wire

FILE: bench/tb_priority_ready_queue_unit.sv
`timescale 1ns / 1ps

module tb_priority_ready_queue_unit;

	localparam int SLOTS = 16;
	localparam int PRIORITY_BITS = 8;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic       pv;
		logic [4:0] pid;
		logic       ovf;
	} outcome_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] operation = prq_pkg::OP_NOP;
	logic [4:0] task_id = '0;
	logic [7:0] task_priority = '0;
	logic       ready_flag = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       picked_valid;
	logic [4:0] picked_id;
	logic       overflow;

	logic [4:0]               shadow_id [SLOTS];
	logic [PRIORITY_BITS-1:0] shadow_prio [SLOTS];
	logic                     shadow_rdy [SLOTS];
	outcome_t                 due_outcomes [$];

	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   errors = 0;
	logic hold_arm = 1'b0;
	int   hold_left = 0;

	priority_ready_queue_unit #(
		.SLOTS(SLOTS),
		.PRIORITY_BITS(PRIORITY_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.task_id(task_id),
		.task_priority(task_priority),
		.ready_flag(ready_flag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.picked_valid(picked_valid),
		.picked_id(picked_id),
		.overflow(overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic schedule_word(input prq_pkg::op_t op, input logic [4:0] id,
			input logic [7:0] prio_in, input logic rdy);
		outcome_t                 res;
		logic [4:0]               cur_id;
		logic [PRIORITY_BITS-1:0] cur_prio;
		logic                     cur_rdy;
		logic [4:0]               tmp_id;
		logic [PRIORITY_BITS-1:0] tmp_prio;
		logic                     tmp_rdy;
		logic                     moving;
		logic                     done;
		int                       k;
		int                       j;
		res = '0;
		cur_id = id;
		cur_prio = prio_in[PRIORITY_BITS-1:0];
		cur_rdy = rdy;
		moving = 1'b0;
		done = 1'b0;
		case (op)
			prq_pkg::OP_ENQUEUE: begin
				if (id != 0) begin
					for (k = 0; k < SLOTS; k++) begin
						if (!done) begin
							if (shadow_id[k] == 0) begin
								shadow_id[k] = cur_id;
								shadow_prio[k] = cur_prio;
								shadow_rdy[k] = cur_rdy;
								done = 1'b1;
							end else begin
								if (shadow_prio[k] < cur_prio)
									moving = 1'b1;
								if (moving) begin
									tmp_id = shadow_id[k];
									tmp_prio = shadow_prio[k];
									tmp_rdy = shadow_rdy[k];
									shadow_id[k] = cur_id;
									shadow_prio[k] = cur_prio;
									shadow_rdy[k] = cur_rdy;
									cur_id = tmp_id;
									cur_prio = tmp_prio;
									cur_rdy = tmp_rdy;
								end
							end
						end
					end
					if (!done)
						res.ovf = 1'b1;
				end
			end
			prq_pkg::OP_SET_READY: begin
				if (id != 0) begin
					for (k = 0; k < SLOTS; k++) begin
						if (shadow_id[k] != 0 && shadow_id[k] == cur_id
								&& shadow_prio[k] == cur_prio)
							shadow_rdy[k] = cur_rdy;
					end
				end
			end
			prq_pkg::OP_PICK: begin
				for (k = 0; k < SLOTS; k++) begin
					if (!done && shadow_id[k] != 0 && shadow_rdy[k]) begin
						res.pv = 1'b1;
						res.pid = shadow_id[k];
						for (j = k + 1; j < SLOTS; j++) begin
							shadow_id[j-1] = shadow_id[j];
							shadow_prio[j-1] = shadow_prio[j];
							shadow_rdy[j-1] = shadow_rdy[j];
						end
						shadow_id[SLOTS-1] = '0;
						shadow_prio[SLOTS-1] = '0;
						shadow_rdy[SLOTS-1] = 1'b0;
						done = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		due_outcomes.push_back(res);
	endtask

	task automatic send_word(input prq_pkg::op_t op, input logic [4:0] id,
			input logic [7:0] prio_in, input logic rdy);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		operation <= op;
		task_id <= id;
		task_priority <= prio_in;
		ready_flag <= rdy;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		schedule_word(op, id, prio_in, rdy);
	endtask

	task automatic test_basic_ops();
		send_word(prq_pkg::OP_PICK, 5'd0, 8'd0, 1'b0);
		send_word(prq_pkg::OP_ENQUEUE, 5'd0, 8'd255, 1'b1);
		send_word(prq_pkg::OP_SET_READY, 5'd0, 8'd0, 1'b1);
		send_word(prq_pkg::OP_NOP, 5'd31, 8'd255, 1'b1);
		send_word(prq_pkg::OP_ENQUEUE, 5'd31, 8'd255, 1'b1);
		send_word(prq_pkg::OP_ENQUEUE, 5'd1, 8'd0, 1'b0);
		send_word(prq_pkg::OP_ENQUEUE, 5'd16, 8'd255, 1'b0);
		send_word(prq_pkg::OP_SET_READY, 5'd16, 8'd254, 1'b1);
		send_word(prq_pkg::OP_SET_READY, 5'd16, 8'd255, 1'b1);
		send_word(prq_pkg::OP_PICK, 5'd31, 8'd255, 1'b1);
		send_word(prq_pkg::OP_PICK, 5'd0, 8'd0, 1'b0);
		send_word(prq_pkg::OP_PICK, 5'd0, 8'd0, 1'b0);
		send_word(prq_pkg::OP_SET_READY, 5'd1, 8'd0, 1'b1);
		send_word(prq_pkg::OP_PICK, 5'd0, 8'd0, 1'b0);
		send_word(prq_pkg::OP_PICK, 5'd0, 8'd0, 1'b0);
	endtask

	task automatic test_full_queue();
		int k;
		for (k = 1; k <= SLOTS; k++)
			send_word(prq_pkg::OP_ENQUEUE, k[4:0], 8'($urandom_range(1, 254)),
				1'($urandom_range(1)));
		send_word(prq_pkg::OP_ENQUEUE, 5'd17, 8'd0, 1'b1);
		send_word(prq_pkg::OP_ENQUEUE, 5'd20, 8'd255, 1'b0);
		send_word(prq_pkg::OP_SET_READY, 5'd20, 8'd255, 1'b1);
		send_word(prq_pkg::OP_PICK, 5'd0, 8'd0, 1'b0);
		send_word(prq_pkg::OP_PICK, 5'd0, 8'd0, 1'b0);
	endtask

	task automatic test_random_mix(input int count);
		int           k;
		int           r;
		int           j;
		int           occupied;
		int           enq_pct;
		prq_pkg::op_t op;
		logic [4:0]   id;
		logic [7:0]   prio_val;
		logic         rdy;
		enq_pct = 50;
		for (k = 0; k < count; k++) begin
			if (k % 50 == 0)
				enq_pct = $urandom_range(20, 70);
			occupied = 0;
			for (j = 0; j < SLOTS; j++)
				if (shadow_id[j] != 0)
					occupied++;
			id = 5'($urandom_range(31));
			case ($urandom_range(7))
				0: prio_val = 8'd0;
				1: prio_val = 8'd255;
				2: prio_val = 8'd7;
				3: prio_val = 8'd128;
				default: prio_val = 8'($urandom_range(255));
			endcase
			rdy = 1'($urandom_range(1));
			r = $urandom_range(99);
			if (r < enq_pct) begin
				op = prq_pkg::OP_ENQUEUE;
			end else if (r < enq_pct + (100 - enq_pct) * 2 / 5) begin
				op = prq_pkg::OP_SET_READY;
				if (occupied > 0 && $urandom_range(3) != 0) begin
					j = $urandom_range(occupied - 1);
					id = shadow_id[j];
					prio_val = 8'(shadow_prio[j]);
				end
			end else if (r < 97) begin
				op = prq_pkg::OP_PICK;
			end else begin
				op = prq_pkg::OP_NOP;
			end
			send_word(op, id, prio_val, rdy);
		end
	endtask

	task automatic test_backpressure();
		hold_arm <= 1'b1;
		test_random_mix(40);
	endtask

	initial begin
		for (int k = 0; k < SLOTS; k++) begin
			shadow_id[k] = '0;
			shadow_prio[k] = '0;
			shadow_rdy[k] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_full_queue();
		test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_mix(200);
		send_idle_pct = 54;
		recv_stall_pct = 0;
		test_random_mix(200);
		send_idle_pct = 0;
		recv_stall_pct = 54;
		test_random_mix(200);
		send_idle_pct = 22;
		recv_stall_pct = 22;
		test_random_mix(200);
		in_valid <= 1'b0;
		wait (due_outcomes.size() == 0);
		repeat (SLOTS + 8) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_arm) begin
			hold_arm <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_outcomes.size() == 0) begin
				$error("unexpected word: picked_valid %0d picked_id %0d overflow %0d",
					picked_valid, picked_id, overflow);
				errors++;
			end else begin
				want = due_outcomes.pop_front();
				if (picked_valid !== want.pv) begin
					$error("picked_valid expected %0d actual %0d", want.pv, picked_valid);
					errors++;
				end
				if (picked_id !== want.pid) begin
					$error("picked_id expected %0d actual %0d", want.pid, picked_id);
					errors++;
				end
				if (overflow !== want.ovf) begin
					$error("overflow expected %0d actual %0d", want.ovf, overflow);
					errors++;
				end
			end
		end
		if (hold_arm || hold_left != 0)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
